### hdl/vfrq_pkg.sv
// ----------------------------------------------------------------------------
// vfrq_pkg
// Shared types and constants for the vCPU FIFO ready queue: operation codes,
// list commands and status, and the membership and sequencer encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package vfrq_pkg;

    localparam int MAX_VCPUS = 16;
    localparam int ID_W      = 4;
    localparam int ST_W      = 3;
    localparam int FUNC_W    = 3;
    localparam int ADDR_W    = $clog2(MAX_VCPUS);
    localparam int LEN_W     = $clog2(MAX_VCPUS + 1);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD        = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_STATE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SCHED_NEXT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCHED_NOW  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PICK       = 3'd4;

    // vcpu state codes
    localparam logic [ST_W-1:0] ST_READY   = 3'd0;
    localparam logic [ST_W-1:0] ST_SUSPEND = 3'd1;
    localparam logic [ST_W-1:0] ST_IDLE    = 3'd2;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READY = 2'd1,
        MEM_SLEEP = 2'd2
    } member_t;

    typedef enum logic [1:0] {
        PLACE_NONE,
        PLACE_READY_HEAD,
        PLACE_READY_TAIL,
        PLACE_SLEEP_TAIL
    } place_t;

    typedef enum logic [1:0] {
        LIST_REMOVE,
        LIST_PUSH_HEAD,
        LIST_PUSH_TAIL,
        LIST_READ_HEAD
    } list_op_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_SCAN,
        LS_SHIFT
    } list_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_UNLINK,
        T_UNLINK_WAIT,
        T_INSERT,
        T_INSERT_WAIT,
        T_HEAD,
        T_HEAD_WAIT,
        T_DONE
    } top_state_t;

    typedef struct packed {
        logic            valid;
        list_op_t        op;
        logic [ID_W-1:0] id;
    } list_cmd_t;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [ID_W-1:0]  head;
        logic [LEN_W-1:0] len;
    } list_status_t;

endpackage

`default_nettype wire

### hdl/vfrq_ram.sv
// ----------------------------------------------------------------------------
// vfrq_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vfrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/vfrq_list.sv
// ----------------------------------------------------------------------------
// vfrq_list
// One ordered list of vCPU ids held in a RAM with a length register. Removal
// streams the list through the read port and compacts it one entry a cycle;
// head insertion shifts entries up one a cycle; tail insertion is one write.
// ----------------------------------------------------------------------------
`default_nettype none

module vfrq_list (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire vfrq_pkg::list_cmd_t    cmd,
    output vfrq_pkg::list_status_t      status
);

    vfrq_pkg::list_state_t state_reg, state_next;

    logic [vfrq_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [vfrq_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [vfrq_pkg::ID_W-1:0]   id_reg, id_next;
    logic                        found_reg, found_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [vfrq_pkg::ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic                        done_reg, done_next;
    logic                        ok_reg, ok_next;

    logic                        wr_en;
    logic [vfrq_pkg::ADDR_W-1:0] wr_addr;
    logic [vfrq_pkg::ID_W-1:0]   wr_data;
    logic                        rd_en;
    logic [vfrq_pkg::ADDR_W-1:0] rd_addr;
    logic [vfrq_pkg::ID_W-1:0]   rd_data;
    logic [vfrq_pkg::LEN_W-1:0]  idx_m1;
    logic                        has_room;

    assign idx_m1   = idx_reg - vfrq_pkg::LEN_W'(1);
    assign has_room = (32'(len_reg) < vfrq_pkg::MAX_VCPUS);

    vfrq_ram #(
        .WIDTH (vfrq_pkg::ID_W),
        .DEPTH (vfrq_pkg::MAX_VCPUS)
    ) u_order_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vfrq_pkg::LS_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.op == vfrq_pkg::LIST_REMOVE && len_reg != '0)
                    begin
                        state_next = vfrq_pkg::LS_SCAN;
                    end
                    else if (cmd.op == vfrq_pkg::LIST_PUSH_HEAD && has_room)
                    begin
                        state_next = vfrq_pkg::LS_SHIFT;
                    end
                end
            end
            vfrq_pkg::LS_SCAN:
            begin
                if (idx_reg == len_reg && !rd_pend_reg)
                begin
                    state_next = vfrq_pkg::LS_IDLE;
                end
            end
            vfrq_pkg::LS_SHIFT:
            begin
                if (idx_reg == '0 && !rd_pend_reg)
                begin
                    state_next = vfrq_pkg::LS_IDLE;
                end
            end
            default:
            begin
                state_next = vfrq_pkg::LS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next     = idx_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        found_next   = found_reg;
        rd_pend_next = 1'b0;
        rd_addr_next = rd_addr_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = id_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        case (state_reg)
            vfrq_pkg::LS_IDLE:
            begin
                if (cmd.valid)
                begin
                    id_next = cmd.id;
                    case (cmd.op)
                        vfrq_pkg::LIST_REMOVE:
                        begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            if (len_reg == '0)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                        end
                        vfrq_pkg::LIST_PUSH_HEAD:
                        begin
                            idx_next = len_reg;
                            if (!has_room)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                        end
                        vfrq_pkg::LIST_PUSH_TAIL:
                        begin
                            done_next = 1'b1;
                            ok_next   = has_room;
                            if (has_room)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = len_reg[vfrq_pkg::ADDR_W-1:0];
                                wr_data  = cmd.id;
                                len_next = len_reg + vfrq_pkg::LEN_W'(1);
                            end
                        end
                        vfrq_pkg::LIST_READ_HEAD:
                        begin
                            // head shows on rd_data when done rises
                            rd_en     = 1'b1;
                            rd_addr   = '0;
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            vfrq_pkg::LS_SCAN:
            begin
                if (idx_reg != len_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[vfrq_pkg::ADDR_W-1:0];
                    rd_addr_next = idx_reg[vfrq_pkg::ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + vfrq_pkg::LEN_W'(1);
                end
                if (rd_pend_reg)
                begin
                    // entries after the match slide down by one
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_addr_reg - vfrq_pkg::ADDR_W'(1);
                        wr_data = rd_data;
                    end
                    else if (rd_data == id_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (idx_reg == len_reg && !rd_pend_reg)
                begin
                    done_next = 1'b1;
                    ok_next   = found_reg;
                    if (found_reg)
                    begin
                        len_next = len_reg - vfrq_pkg::LEN_W'(1);
                    end
                end
            end
            vfrq_pkg::LS_SHIFT:
            begin
                // walk from the tail down so no entry is overwritten before it is read
                if (idx_reg != '0)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_m1[vfrq_pkg::ADDR_W-1:0];
                    rd_addr_next = idx_m1[vfrq_pkg::ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    idx_next     = idx_m1;
                end
                if (rd_pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_reg + vfrq_pkg::ADDR_W'(1);
                    wr_data = rd_data;
                end
                if (idx_reg == '0 && !rd_pend_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    wr_data   = id_reg;
                    len_next  = len_reg + vfrq_pkg::LEN_W'(1);
                    done_next = 1'b1;
                    ok_next   = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vfrq_pkg::LS_IDLE;
            len_reg     <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            ok_reg      <= ok_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        rd_addr_reg <= rd_addr_next;
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;
    assign status.head = rd_data;
    assign status.len  = len_reg;

endmodule

`default_nettype wire

### hdl/vcpu_fifo_ready_queue.sv
// Flow: an item that leaves the lists alone reads the ready-list head and loads its result;
// one that moves a vCPU first removes it with a scan of its list when it is listed, then
// inserts it (a head insertion into the ready list shifts its entries up one at a time),
// then reads the head; every step goes through the list RAM ports.
// Items are taken one at a time; a finished result waits in the output register while
// the next item is taken. Reset: lists empty, no vCPU listed, states 0, idle_vcpu 0.
// ----------------------------------------------------------------------------
// vcpu_fifo_ready_queue
// Per-processor FIFO run queue: ready and sleep lists of vCPU ids in RAM,
// per-vCPU membership and recorded state in flops, one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module vcpu_fifo_ready_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vfrq_pkg::ID_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [vfrq_pkg::FUNC_W-1:0]   func,
    input  wire logic [vfrq_pkg::ID_W-1:0]     vcpu_id,
    input  wire logic [vfrq_pkg::ST_W-1:0]     new_state,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [vfrq_pkg::ID_W-1:0]     picked_vcpu,
    output logic                               picked_is_idle,
    output logic      [vfrq_pkg::ST_W-1:0]     vcpu_state,
    output logic      [vfrq_pkg::LEN_W-1:0]    ready_count,
    output logic      [vfrq_pkg::LEN_W-1:0]    sleep_count
);

    vfrq_pkg::top_state_t state_reg, state_next;

    logic [vfrq_pkg::ID_W-1:0]   idle_vcpu_reg;
    logic [vfrq_pkg::ID_W-1:0]   id_reg;
    logic                        id_ok_reg;
    vfrq_pkg::place_t            place_reg;
    vfrq_pkg::member_t           member_reg [vfrq_pkg::MAX_VCPUS];
    logic [vfrq_pkg::ST_W-1:0]   rec_state_reg [vfrq_pkg::MAX_VCPUS];
    logic [vfrq_pkg::ID_W-1:0]   head_reg;

    logic                        out_valid_reg;
    logic [vfrq_pkg::ID_W-1:0]   picked_vcpu_reg;
    logic                        picked_is_idle_reg;
    logic [vfrq_pkg::ST_W-1:0]   vcpu_state_reg;
    logic [vfrq_pkg::LEN_W-1:0]  ready_count_reg;
    logic [vfrq_pkg::LEN_W-1:0]  sleep_count_reg;

    vfrq_pkg::list_cmd_t         ready_cmd, sleep_cmd;
    vfrq_pkg::list_status_t      ready_st, sleep_st;

    logic                        in_fire;
    logic                        id_ok;
    logic                        is_idle;
    vfrq_pkg::place_t            place_in;
    logic                        rec_we;
    logic [vfrq_pkg::ST_W-1:0]   rec_val;
    logic [vfrq_pkg::ADDR_W-1:0] id_idx;
    logic [vfrq_pkg::ADDR_W-1:0] in_idx;
    vfrq_pkg::member_t           cur_member;
    logic                        member_we;
    vfrq_pkg::member_t           member_val;
    logic                        out_load;

    assign in_ready  = (state_reg == vfrq_pkg::T_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign id_idx    = id_reg[vfrq_pkg::ADDR_W-1:0];
    assign in_idx    = vcpu_id[vfrq_pkg::ADDR_W-1:0];
    assign cur_member = member_reg[id_idx];
    assign out_load  = (state_reg == vfrq_pkg::T_DONE) && (!out_valid_reg || out_ready);

    vfrq_list u_ready_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ready_cmd),
        .status (ready_st)
    );

    vfrq_list u_sleep_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (sleep_cmd),
        .status (sleep_st)
    );

    // decode of the incoming item
    always_comb
    begin
        id_ok    = (32'(vcpu_id) < vfrq_pkg::MAX_VCPUS);
        is_idle  = (vcpu_id == idle_vcpu_reg);
        place_in = vfrq_pkg::PLACE_NONE;
        rec_we   = 1'b0;
        rec_val  = new_state;
        if (id_ok)
        begin
            case (func)
                vfrq_pkg::FUNC_ADD:
                begin
                    if (!is_idle)
                    begin
                        place_in = vfrq_pkg::PLACE_SLEEP_TAIL;
                        rec_we   = 1'b1;
                        rec_val  = vfrq_pkg::ST_IDLE;
                    end
                end
                vfrq_pkg::FUNC_SET_STATE:
                begin
                    if (!is_idle)
                    begin
                        rec_we = 1'b1;
                        if (new_state == vfrq_pkg::ST_READY)
                        begin
                            place_in = vfrq_pkg::PLACE_READY_HEAD;
                        end
                        else if (new_state inside {vfrq_pkg::ST_SUSPEND, vfrq_pkg::ST_IDLE})
                        begin
                            place_in = vfrq_pkg::PLACE_SLEEP_TAIL;
                        end
                    end
                end
                vfrq_pkg::FUNC_SCHED_NEXT:
                begin
                    if (!is_idle)
                    begin
                        place_in = vfrq_pkg::PLACE_READY_TAIL;
                    end
                end
                vfrq_pkg::FUNC_SCHED_NOW:
                begin
                    place_in = vfrq_pkg::PLACE_READY_HEAD;
                end
                vfrq_pkg::FUNC_PICK:
                begin
                    place_in = vfrq_pkg::PLACE_NONE;
                end
                default:
                begin
                    place_in = vfrq_pkg::PLACE_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vfrq_pkg::T_IDLE:
            begin
                if (in_fire)
                begin
                    if (place_in == vfrq_pkg::PLACE_NONE)
                    begin
                        state_next = vfrq_pkg::T_HEAD;
                    end
                    else
                    begin
                        state_next = vfrq_pkg::T_UNLINK;
                    end
                end
            end
            vfrq_pkg::T_UNLINK:
            begin
                if (cur_member == vfrq_pkg::MEM_NONE)
                begin
                    state_next = vfrq_pkg::T_INSERT;
                end
                else
                begin
                    state_next = vfrq_pkg::T_UNLINK_WAIT;
                end
            end
            vfrq_pkg::T_UNLINK_WAIT:
            begin
                if (ready_st.done || sleep_st.done)
                begin
                    state_next = vfrq_pkg::T_INSERT;
                end
            end
            vfrq_pkg::T_INSERT:
            begin
                state_next = vfrq_pkg::T_INSERT_WAIT;
            end
            vfrq_pkg::T_INSERT_WAIT:
            begin
                if (ready_st.done || sleep_st.done)
                begin
                    state_next = vfrq_pkg::T_HEAD;
                end
            end
            vfrq_pkg::T_HEAD:
            begin
                state_next = vfrq_pkg::T_HEAD_WAIT;
            end
            vfrq_pkg::T_HEAD_WAIT:
            begin
                if (ready_st.done)
                begin
                    state_next = vfrq_pkg::T_DONE;
                end
            end
            vfrq_pkg::T_DONE:
            begin
                if (out_load)
                begin
                    state_next = vfrq_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = vfrq_pkg::T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready_cmd       = '0;
        sleep_cmd       = '0;
        ready_cmd.id    = id_reg;
        sleep_cmd.id    = id_reg;
        ready_cmd.op    = vfrq_pkg::LIST_READ_HEAD;
        sleep_cmd.op    = vfrq_pkg::LIST_PUSH_TAIL;
        member_we       = 1'b0;
        member_val      = vfrq_pkg::MEM_NONE;
        case (state_reg)
            vfrq_pkg::T_UNLINK:
            begin
                member_we  = 1'b1;
                member_val = vfrq_pkg::MEM_NONE;
                if (cur_member == vfrq_pkg::MEM_READY)
                begin
                    ready_cmd.valid = 1'b1;
                    ready_cmd.op    = vfrq_pkg::LIST_REMOVE;
                end
                else if (cur_member == vfrq_pkg::MEM_SLEEP)
                begin
                    sleep_cmd.valid = 1'b1;
                    sleep_cmd.op    = vfrq_pkg::LIST_REMOVE;
                end
            end
            vfrq_pkg::T_INSERT:
            begin
                case (place_reg)
                    vfrq_pkg::PLACE_READY_HEAD:
                    begin
                        ready_cmd.valid = 1'b1;
                        ready_cmd.op    = vfrq_pkg::LIST_PUSH_HEAD;
                    end
                    vfrq_pkg::PLACE_READY_TAIL:
                    begin
                        ready_cmd.valid = 1'b1;
                        ready_cmd.op    = vfrq_pkg::LIST_PUSH_TAIL;
                    end
                    vfrq_pkg::PLACE_SLEEP_TAIL:
                    begin
                        sleep_cmd.valid = 1'b1;
                        sleep_cmd.op    = vfrq_pkg::LIST_PUSH_TAIL;
                    end
                    default:
                    begin
                        ready_cmd.valid = 1'b0;
                    end
                endcase
            end
            vfrq_pkg::T_INSERT_WAIT:
            begin
                // membership follows only an insertion that fit
                if (ready_st.done && ready_st.ok)
                begin
                    member_we  = 1'b1;
                    member_val = vfrq_pkg::MEM_READY;
                end
                else if (sleep_st.done && sleep_st.ok)
                begin
                    member_we  = 1'b1;
                    member_val = vfrq_pkg::MEM_SLEEP;
                end
            end
            vfrq_pkg::T_HEAD:
            begin
                ready_cmd.valid = 1'b1;
                ready_cmd.op    = vfrq_pkg::LIST_READ_HEAD;
            end
            default:
            begin
                member_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vfrq_pkg::T_IDLE;
            idle_vcpu_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < vfrq_pkg::MAX_VCPUS; i++)
            begin
                member_reg[i]    <= vfrq_pkg::MEM_NONE;
                rec_state_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                idle_vcpu_reg <= cfg_data;
            end
            if (in_fire && rec_we)
            begin
                rec_state_reg[in_idx] <= rec_val;
            end
            if (member_we)
            begin
                member_reg[id_idx] <= member_val;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            id_reg    <= vcpu_id;
            id_ok_reg <= id_ok;
            place_reg <= place_in;
        end
        if (state_reg == vfrq_pkg::T_HEAD_WAIT && ready_st.done)
        begin
            head_reg <= ready_st.head;
        end
        if (out_load)
        begin
            picked_is_idle_reg <= (ready_st.len == '0);
            picked_vcpu_reg    <= (ready_st.len == '0) ? idle_vcpu_reg : head_reg;
            vcpu_state_reg     <= id_ok_reg ? rec_state_reg[id_idx] : '0;
            ready_count_reg    <= ready_st.len;
            sleep_count_reg    <= sleep_st.len;
        end
    end

    assign out_valid      = out_valid_reg;
    assign picked_vcpu    = picked_vcpu_reg;
    assign picked_is_idle = picked_is_idle_reg;
    assign vcpu_state     = vcpu_state_reg;
    assign ready_count    = ready_count_reg;
    assign sleep_count    = sleep_count_reg;

`ifndef NO_ASSERTIONS
    a_lists_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ready_st.len) + 32'(sleep_st.len)) <= vfrq_pkg::MAX_VCPUS)
        else $error("ready and sleep lists hold more entries than vcpus");

    a_one_list_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready_st.done && sleep_st.done))
        else $error("both lists finished a command in the same cycle");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("next item taken before the current one finished");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (picked_is_idle == (ready_count == '0)))
        else $error("idle flag disagrees with ready count");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_vcpu_fifo_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vcpu_fifo_ready_queue
// Self-checking bench for the vCPU FIFO run queue. A directed pass walks every
// operation and corner case, then random op streams, mixed with whole-list
// sweeps, run under several idle-vCPU settings. Each result is checked field
// by field against a queue-based model of the ready and sleep lists.
// ----------------------------------------------------------------------------
module tb_vcpu_fifo_ready_queue;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int GAP_PCT      = 22;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * vfrq_pkg::MAX_VCPUS + 20;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 5;

    localparam logic [vfrq_pkg::FUNC_W-1:0] FUNC_MAX = {vfrq_pkg::FUNC_W{1'b1}};
    localparam logic [vfrq_pkg::ST_W-1:0]   ST_MAX   = {vfrq_pkg::ST_W{1'b1}};
    localparam logic [vfrq_pkg::ID_W-1:0]   ID_MAX   = {vfrq_pkg::ID_W{1'b1}};

    typedef struct packed {
        logic [vfrq_pkg::FUNC_W-1:0] func;
        logic [vfrq_pkg::ID_W-1:0]   id;
        logic [vfrq_pkg::ST_W-1:0]   st;
    } sched_op_t;

    typedef struct packed {
        logic [vfrq_pkg::ID_W-1:0]  picked;
        logic                       picked_idle;
        logic [vfrq_pkg::ST_W-1:0]  st;
        logic [vfrq_pkg::LEN_W-1:0] n_ready;
        logic [vfrq_pkg::LEN_W-1:0] n_sleep;
    } sched_view_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [vfrq_pkg::ID_W-1:0]   cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic [vfrq_pkg::FUNC_W-1:0] func      = '0;
    logic [vfrq_pkg::ID_W-1:0]   vcpu_id   = '0;
    logic [vfrq_pkg::ST_W-1:0]   new_state = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [vfrq_pkg::ID_W-1:0]   picked_vcpu;
    logic                        picked_is_idle;
    logic [vfrq_pkg::ST_W-1:0]   vcpu_state;
    logic [vfrq_pkg::LEN_W-1:0]  ready_count;
    logic [vfrq_pkg::LEN_W-1:0]  sleep_count;

    // list model
    logic [vfrq_pkg::ID_W-1:0] run_list[$];
    logic [vfrq_pkg::ID_W-1:0] doze_list[$];
    vfrq_pkg::member_t         where_on[vfrq_pkg::MAX_VCPUS];
    logic [vfrq_pkg::ST_W-1:0] state_of[vfrq_pkg::MAX_VCPUS];
    logic [vfrq_pkg::ID_W-1:0] idle_id = '0;

    sched_op_t   op_backlog[$];
    sched_view_t expected_views[$];

    bit no_gaps      = 1'b0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int idle_picks   = 0;
    int cfg_writes   = 0;
    int peak_ready   = 0;
    int peak_sleep   = 0;
    int func_seen[2**vfrq_pkg::FUNC_W];

    vcpu_fifo_ready_queue u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .vcpu_id        (vcpu_id),
        .new_state      (new_state),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .picked_vcpu    (picked_vcpu),
        .picked_is_idle (picked_is_idle),
        .vcpu_state     (vcpu_state),
        .ready_count    (ready_count),
        .sleep_count    (sleep_count)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void unlink(input logic [vfrq_pkg::ID_W-1:0] id);
        if (where_on[id] == vfrq_pkg::MEM_READY)
        begin
            foreach (run_list[i])
            begin
                if (run_list[i] == id)
                begin
                    run_list.delete(i);
                    break;
                end
            end
        end
        else if (where_on[id] == vfrq_pkg::MEM_SLEEP)
        begin
            foreach (doze_list[i])
            begin
                if (doze_list[i] == id)
                begin
                    doze_list.delete(i);
                    break;
                end
            end
        end
        where_on[id] = vfrq_pkg::MEM_NONE;
    endfunction

    function automatic void to_ready(input logic [vfrq_pkg::ID_W-1:0] id, input bit at_head);
        unlink(id);
        if (run_list.size() < vfrq_pkg::MAX_VCPUS)
        begin
            if (at_head)
                run_list.push_front(id);
            else
                run_list.push_back(id);
            where_on[id] = vfrq_pkg::MEM_READY;
        end
    endfunction

    function automatic void to_sleep(input logic [vfrq_pkg::ID_W-1:0] id);
        unlink(id);
        if (doze_list.size() < vfrq_pkg::MAX_VCPUS)
        begin
            doze_list.push_back(id);
            where_on[id] = vfrq_pkg::MEM_SLEEP;
        end
    endfunction

    // apply one op to the model and return what the queue reports afterwards
    function automatic sched_view_t schedule_step(input sched_op_t op);
        sched_view_t view;
        bit          is_idle;
        is_idle = (op.id == idle_id);
        case (op.func)
            vfrq_pkg::FUNC_ADD:
                if (!is_idle)
                begin
                    to_sleep(op.id);
                    state_of[op.id] = vfrq_pkg::ST_IDLE;
                end
            vfrq_pkg::FUNC_SET_STATE:
                if (!is_idle)
                begin
                    if (op.st == vfrq_pkg::ST_READY)
                        to_ready(op.id, 1'b1);
                    else if (op.st == vfrq_pkg::ST_SUSPEND || op.st == vfrq_pkg::ST_IDLE)
                        to_sleep(op.id);
                    state_of[op.id] = op.st;
                end
            vfrq_pkg::FUNC_SCHED_NEXT:
                if (!is_idle)
                    to_ready(op.id, 1'b0);
            vfrq_pkg::FUNC_SCHED_NOW:
                to_ready(op.id, 1'b1);
            default: ;
        endcase
        if (run_list.size() > 0)
        begin
            view.picked      = run_list[0];
            view.picked_idle = 1'b0;
        end
        else
        begin
            view.picked      = idle_id;
            view.picked_idle = 1'b1;
        end
        view.st      = state_of[op.id];
        view.n_ready = vfrq_pkg::LEN_W'(run_list.size());
        view.n_sleep = vfrq_pkg::LEN_W'(doze_list.size());
        if (run_list.size() > peak_ready)
            peak_ready = run_list.size();
        if (doze_list.size() > peak_sleep)
            peak_sleep = doze_list.size();
        return view;
    endfunction

    function automatic void report_mismatch(input string what, input logic [7:0] want,
                                            input logic [7:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endfunction

    task automatic queue_op(input logic [vfrq_pkg::FUNC_W-1:0] fn,
                            input logic [vfrq_pkg::ID_W-1:0] id,
                            input logic [vfrq_pkg::ST_W-1:0] st);
        op_backlog.push_back({fn, id, st});
    endtask

    task automatic write_idle_vcpu(input logic [vfrq_pkg::ID_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        idle_id = value;
        cfg_writes++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (op_backlog.size() != 0 || in_valid || expected_views.size() != 0);
    endtask

    // item driver
    always @(posedge clk)
    begin : drive_items
        sched_op_t next_op;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_views.push_back(schedule_step({func, vcpu_id, new_state}));
                func_seen[func]++;
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (op_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT))
                begin
                    next_op = op_backlog.pop_front();
                    in_valid  <= 1'b1;
                    func      <= next_op.func;
                    vcpu_id   <= next_op.id;
                    new_state <= next_op.st;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        sched_view_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                    report_mismatch("result with no item outstanding, picked_vcpu", '0,
                                    8'(picked_vcpu));
                else
                begin
                    want = expected_views.pop_front();
                    results_seen++;
                    if (want.picked_idle)
                        idle_picks++;
                    check_field("picked_vcpu", 8'(want.picked), 8'(picked_vcpu));
                    check_field("picked_is_idle", 8'(want.picked_idle), 8'(picked_is_idle));
                    check_field("vcpu_state", 8'(want.st), 8'(vcpu_state));
                    check_field("ready_count", 8'(want.n_ready), 8'(ready_count));
                    check_field("sleep_count", 8'(want.n_sleep), 8'(sleep_count));
                end
            end
            out_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_views.size());
                $display("tb_vcpu_fifo_ready_queue failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run_phases
        logic [vfrq_pkg::ID_W-1:0]   order[vfrq_pkg::MAX_VCPUS];
        logic [vfrq_pkg::ID_W-1:0]   swap_id;
        logic [vfrq_pkg::ID_W-1:0]   id;
        logic [vfrq_pkg::FUNC_W-1:0] fn;
        logic [vfrq_pkg::ST_W-1:0]   st;
        logic [vfrq_pkg::ID_W-1:0]   setting;
        int                          j;
        int                          r;
        int                          n;

        for (int v = 0; v < vfrq_pkg::MAX_VCPUS; v++)
        begin
            where_on[v] = vfrq_pkg::MEM_NONE;
            state_of[v] = '0;
        end
        foreach (func_seen[k])
            func_seen[k] = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        write_idle_vcpu(ID_MAX);
        queue_op(vfrq_pkg::FUNC_PICK, '0, vfrq_pkg::ST_READY);        // empty ready list
        queue_op(vfrq_pkg::FUNC_ADD, ID_MAX, ST_MAX);                 // idle vCPU is ignored
        queue_op(vfrq_pkg::FUNC_ADD, '0, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_ADD, 4'd3, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_ADD, '0, vfrq_pkg::ST_READY);         // re-add moves to tail
        queue_op(vfrq_pkg::FUNC_SET_STATE, 4'd3, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SET_STATE, '0, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SCHED_NEXT, 4'd5, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SCHED_NOW, 4'd5, vfrq_pkg::ST_READY); // already ready, to head
        queue_op(vfrq_pkg::FUNC_SCHED_NEXT, '0, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SET_STATE, 4'd3, vfrq_pkg::ST_SUSPEND);
        queue_op(vfrq_pkg::FUNC_SET_STATE, 4'd5, vfrq_pkg::ST_IDLE);
        queue_op(vfrq_pkg::FUNC_SET_STATE, '0, vfrq_pkg::ST_IDLE + 3'd1); // recorded only
        queue_op(vfrq_pkg::FUNC_SET_STATE, '0, ST_MAX);
        queue_op(vfrq_pkg::FUNC_SET_STATE, ID_MAX, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SCHED_NEXT, ID_MAX, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SCHED_NOW, ID_MAX, vfrq_pkg::ST_READY); // idle vCPU to head
        queue_op(vfrq_pkg::FUNC_ADD, '0, vfrq_pkg::ST_READY);
        queue_op(vfrq_pkg::FUNC_SET_STATE, ID_MAX, vfrq_pkg::ST_SUSPEND);
        queue_op(vfrq_pkg::FUNC_PICK + 3'd1, 4'd7, 3'd5);             // unused codes act as pick
        queue_op(FUNC_MAX, ID_MAX, ST_MAX);
        queue_op(vfrq_pkg::FUNC_SCHED_NOW, 4'd9, ST_MAX);
        queue_op(vfrq_pkg::FUNC_PICK, 4'd9, vfrq_pkg::ST_READY);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       setting = '0;
                1:       setting = ID_MAX;
                default: setting = vfrq_pkg::ID_W'($urandom_range(ID_MAX));
            endcase
            write_idle_vcpu(setting);
            no_gaps = (p == 2);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(19) == 0)
                begin
                    // sweep every vCPU in shuffled order, fills or drains a list
                    for (int k = 0; k < vfrq_pkg::MAX_VCPUS; k++)
                        order[k] = vfrq_pkg::ID_W'(k);
                    for (int k = vfrq_pkg::MAX_VCPUS - 1; k > 0; k--)
                    begin
                        j = $urandom_range(k);
                        swap_id  = order[k];
                        order[k] = order[j];
                        order[j] = swap_id;
                    end
                    r = $urandom_range(3);
                    fn = (r == 0) ? vfrq_pkg::FUNC_ADD :
                         (r == 1) ? vfrq_pkg::FUNC_SCHED_NEXT :
                         (r == 2) ? vfrq_pkg::FUNC_SCHED_NOW : vfrq_pkg::FUNC_SET_STATE;
                    for (int k = 0; k < vfrq_pkg::MAX_VCPUS; k++)
                        queue_op(fn, order[k],
                                 vfrq_pkg::ST_W'($urandom_range(vfrq_pkg::ST_IDLE)));
                    n += vfrq_pkg::MAX_VCPUS;
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 20)
                        fn = vfrq_pkg::FUNC_ADD;
                    else if (r < 50)
                        fn = vfrq_pkg::FUNC_SET_STATE;
                    else if (r < 68)
                        fn = vfrq_pkg::FUNC_SCHED_NEXT;
                    else if (r < 83)
                        fn = vfrq_pkg::FUNC_SCHED_NOW;
                    else if (r < 95)
                        fn = vfrq_pkg::FUNC_PICK;
                    else
                        fn = vfrq_pkg::FUNC_W'($urandom_range(FUNC_MAX, vfrq_pkg::FUNC_PICK + 1));
                    id = ($urandom_range(9) == 0) ? idle_id :
                                                    vfrq_pkg::ID_W'($urandom_range(ID_MAX));
                    st = ($urandom_range(3) == 0) ?
                         vfrq_pkg::ST_W'($urandom_range(ST_MAX)) :
                         vfrq_pkg::ST_W'($urandom_range(vfrq_pkg::ST_IDLE));
                    queue_op(fn, id, st);
                    n++;
                end
            end
        end

        wait_drained();
        no_gaps = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items over %0d idle-vCPU settings: add %0d, set-state %0d,",
                 items_taken, cfg_writes, func_seen[vfrq_pkg::FUNC_ADD],
                 func_seen[vfrq_pkg::FUNC_SET_STATE]);
        $display("  next %0d, now %0d; %0d results checked, %0d idle picks,",
                 func_seen[vfrq_pkg::FUNC_SCHED_NEXT], func_seen[vfrq_pkg::FUNC_SCHED_NOW],
                 results_seen, idle_picks);
        $display("  ready list up to %0d, sleep list up to %0d", peak_ready, peak_sleep);
        if (expected_views.size() != 0)
            $display("%0d results never arrived", expected_views.size());
        if (mismatches == 0 && expected_views.size() == 0)
            $display("tb_vcpu_fifo_ready_queue passed");
        else
            $display("tb_vcpu_fifo_ready_queue failed");
        $finish;
    end

endmodule
